// ===== rtl/lsb_stego_frame_decoder_assert.svh =====
// Assertion macros shared by the frame decoder RTL.
`ifndef LSB_STEGO_FRAME_DECODER_ASSERT_SVH
`define LSB_STEGO_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LSBSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define LSBSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lsbsd_pkg.sv =====
`default_nettype none
package lsbsd_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 64;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_EXT_LEN  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EXT_CHAR = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PAY_LEN  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PAY_BYTE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SKIP  = 2'd2;

	// Configuration reset values
	localparam logic [63:0] MAGIC_WORD_RST   = 64'h232A;
	localparam logic [3:0]  MAGIC_LENGTH_RST = 4'd2;
	localparam logic [15:0] HEADER_SKIP_RST  = 16'd54;

	typedef struct packed {
		logic                valid;
		logic [VALUE_W-1:0]  value;
		logic [KIND_W-1:0]   kind;
		logic                last;
	} lsbsd_res_t;

	typedef struct packed {
		logic [63:0] magic_word;
		logic [3:0]  magic_length;
		logic [15:0] header_skip;
	} lsbsd_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/lsbsd_core.sv =====
`default_nettype none
module lsbsd_core #(
	parameter int unsigned MAX_MAGIC_CHARS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic               data_bit,
	input  wire logic               start,
	input  wire lsbsd_pkg::lsbsd_cfg_t cfg,
	output lsbsd_pkg::lsbsd_res_t   res
);
	import lsbsd_pkg::*;
	`include "lsb_stego_frame_decoder_assert.svh"

	localparam logic [3:0] MaxLen = 4'(MAX_MAGIC_CHARS);

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_MAGIC,
		PH_EXT_LEN,
		PH_EXT_CHARS,
		PH_PAY_LEN,
		PH_PAY,
		PH_IDLE
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] skip_cnt_q, skip_cnt_d;
	logic [4:0]  bit_cnt_q, bit_cnt_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] remain_q, remain_d;
	logic [3:0]  magic_idx_q, magic_idx_d;

	always_comb begin
		phase_t      ph;
		logic [15:0] skp;
		logic [4:0]  bcnt;
		logic [31:0] shf;
		logic [31:0] rem;
		logic [3:0]  midx;
		logic [3:0]  len_eff;
		logic [3:0]  idx;
		logic [3:0]  sel;
		logic [7:0]  expect_byte;
		logic [31:0] sh_new;
		logic        done8;
		logic        done32;
		logic [31:0] rem_dec;

		ph   = start ? PH_SKIP : phase_q;
		skp  = start ? '0 : skip_cnt_q;
		bcnt = start ? '0 : bit_cnt_q;
		shf  = start ? '0 : shift_q;
		rem  = start ? '0 : remain_q;
		midx = start ? '0 : magic_idx_q;

		len_eff = (cfg.magic_length > MaxLen) ? MaxLen : cfg.magic_length;
		idx = (midx < len_eff) ? midx : 4'(len_eff - 4'd1);
		sel = 4'(len_eff - 4'd1 - idx);
		expect_byte = 8'(cfg.magic_word >> {sel[2:0], 3'b000});

		sh_new  = {shf[30:0], data_bit};
		done8   = (bcnt >= 5'd7);
		done32  = (bcnt >= 5'd31);
		rem_dec = rem - 32'd1;

		res = '0;

		// Header skip; fall through to the magic check once done
		if (ph == PH_SKIP) begin
			if (skp < cfg.header_skip) begin
				skp = skp + 16'd1;
			end else begin
				ph = PH_MAGIC;
				midx = '0;
			end
		end
		if (ph == PH_MAGIC && len_eff == 4'd0) begin
			ph = PH_EXT_LEN;
		end

		if (!(phase_q == PH_SKIP && !start && skp != skip_cnt_q) &&
		    !(start && ph == PH_SKIP)) begin
			case (ph)
				PH_MAGIC: begin
					if (done8) begin
						bcnt = '0;
						shf = '0;
						if (sh_new[7:0] != expect_byte) begin
							ph = PH_IDLE;
							res = '{valid: 1'b1, value: '0, kind: KIND_ERROR, last: 1'b1};
						end else begin
							midx = 4'(idx + 4'd1);
							if (midx >= len_eff) ph = PH_EXT_LEN;
						end
					end else begin
						bcnt = 5'(bcnt + 5'd1);
						shf = sh_new;
					end
				end
				PH_EXT_LEN, PH_PAY_LEN: begin
					if (done32) begin
						bcnt = '0;
						shf = '0;
						rem = sh_new;
						res.valid = 1'b1;
						res.value = sh_new;
						if (ph == PH_EXT_LEN) begin
							res.kind = KIND_EXT_LEN;
							ph = (sh_new != '0) ? PH_EXT_CHARS : PH_PAY_LEN;
						end else begin
							res.kind = KIND_PAY_LEN;
							res.last = (sh_new == '0);
							ph = (sh_new != '0) ? PH_PAY : PH_IDLE;
						end
					end else begin
						bcnt = 5'(bcnt + 5'd1);
						shf = sh_new;
					end
				end
				PH_EXT_CHARS, PH_PAY: begin
					if (done8) begin
						bcnt = '0;
						shf = '0;
						rem = rem_dec;
						res.valid = 1'b1;
						res.value = {24'd0, sh_new[7:0]};
						if (ph == PH_EXT_CHARS) begin
							res.kind = KIND_EXT_CHAR;
							if (rem_dec == '0) ph = PH_PAY_LEN;
						end else begin
							res.kind = KIND_PAY_BYTE;
							if (rem_dec == '0) begin
								ph = PH_IDLE;
								res.last = 1'b1;
							end
						end
					end else begin
						bcnt = 5'(bcnt + 5'd1);
						shf = sh_new;
					end
				end
				default: begin
				end
			endcase
		end

		phase_d     = ph;
		skip_cnt_d  = skp;
		bit_cnt_d   = bcnt;
		shift_d     = shf;
		remain_d    = rem;
		magic_idx_d = midx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			skip_cnt_q  <= '0;
			bit_cnt_q   <= '0;
			shift_q     <= '0;
			remain_q    <= '0;
			magic_idx_q <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			skip_cnt_q  <= skip_cnt_d;
			bit_cnt_q   <= bit_cnt_d;
			shift_q     <= shift_d;
			remain_q    <= remain_d;
			magic_idx_q <= magic_idx_d;
		end
	end

	`LSBSD_ASSERT_NEXT(a_idle_holds, clk, arst_n, phase_q == PH_IDLE && !(step && start), phase_q == PH_IDLE, "idle left without start")
	`LSBSD_ASSERT_NOW(a_byte_count, clk, arst_n, phase_q == PH_MAGIC || phase_q == PH_EXT_CHARS || phase_q == PH_PAY, bit_cnt_q < 5'd8, "bit count past a byte")
	`LSBSD_ASSERT_NOW(a_no_result_idle, clk, arst_n, phase_q == PH_IDLE && !start, !res.valid, "result while idle")

endmodule
`default_nettype wire

// ===== rtl/lsb_stego_frame_decoder.sv =====
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  -----------------------------
// input     in         in_valid / in_ready    image_byte, start_req
// result    out        out_valid / out_ready  out_value, kind, last
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One carrier byte per cycle while no result is held: a transfer lands in the
// input register, is decoded once the output register can take its result,
// and that result (if any) sits in the output register, which drives out_valid.
// arst_n clears the frame state and both valid flags and resets the configuration.
// A held result stalls the input register only; in_ready stays high whenever
// the output register is empty or being drained. cfg_ready is always high.
`default_nettype none
module lsb_stego_frame_decoder #(
	parameter int unsigned MAX_MAGIC_CHARS = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       image_byte,
	input  wire logic                             start_req,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [lsbsd_pkg::VALUE_W-1:0]         out_value,
	output logic [lsbsd_pkg::KIND_W-1:0]          kind,
	output logic                                  last,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [lsbsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsbsd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lsbsd_pkg::*;
	`include "lsb_stego_frame_decoder_assert.svh"

	lsbsd_cfg_t cfg_q;
	lsbsd_res_t res;

	logic valid_s1;
	logic bit_s1;
	logic start_s1;
	logic advance;
	logic step;

	logic              out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [KIND_W-1:0]  kind_q;
	logic              last_q;

	// Configuration: always accepted; the block is idle whenever it is written is a rule for the user, not enforced here.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word   <= MAGIC_WORD_RST;
			cfg_q.magic_length <= MAGIC_LENGTH_RST;
			cfg_q.header_skip  <= HEADER_SKIP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAGIC_WORD:   cfg_q.magic_word   <= cfg_data;
				CFG_MAGIC_LENGTH: cfg_q.magic_length <= cfg_data[3:0];
				CFG_HEADER_SKIP:  cfg_q.header_skip  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Decode the staged byte when the output register can take its result.
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register: only bit 0 of the carrier byte carries data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bit_s1   <= image_byte[0];
			start_s1 <= start_req;
		end
	end

	lsbsd_core #(
		.MAX_MAGIC_CHARS(MAX_MAGIC_CHARS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.data_bit(bit_s1),
		.start   (start_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// Output register: load on a decode step, drop on a result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_value_q <= res.value;
			kind_q      <= res.kind;
			last_q      <= res.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign kind      = kind_q;
	assign last      = last_q;

	`LSBSD_ASSERT_NOW(a_err_form, clk, arst_n, out_valid && kind == KIND_ERROR, last && out_value == '0, "malformed error result")
	`LSBSD_ASSERT_NOW(a_len_last, clk, arst_n, out_valid && kind == KIND_PAY_LEN && last, out_value == '0, "last on nonzero payload length")
	`LSBSD_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, valid_s1 && out_valid_q && !out_ready, "input stalled without a held result")

endmodule
`default_nettype wire
